@@ src/mrp_pkg.sv @@
// Shared types and constants for the multi-bulk request parser.
package mrp_pkg;

    typedef enum logic [1:0] {
        PH_LINE     = 2'd0,
        PH_AFTER_CR = 2'd1,
        PH_PAYLOAD  = 2'd2,
        PH_TRAILER  = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        KIND_FRAME = 2'd0,
        KIND_DATA  = 2'd1,
        KIND_DONE  = 2'd2,
        KIND_ERROR = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  payload_byte;
        logic [15:0] arg_number;
        logic        arg_end;
        logic [23:0] header_value;
        logic        header_done;
    } t_result;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam logic [1:0] TRAILER_BYTES = 2'd2;

    localparam int CFG_DATA_W  = 24;
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_ARG_COUNT  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_ARG_LENGTH = 1'b1;

endpackage

@@ src/multibulk_request_parser_unit.sv @@
// Top level of the multi-bulk request parser: parse state, limits and result register.
// An accepted byte's result beat is registered and appears in the next cycle.
// Throughput: one byte per cycle if unstalled; one result register, freed as it drains.
// Reset (synchronous, active low): limits go to all ones, parser awaits a count header,
// result register empties.
module multibulk_request_parser_unit #(
    parameter int COUNT_BITS  = 16,
    parameter int LENGTH_BITS = 24
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [7:0]                       i_data_byte,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [1:0]                       o_kind,
    output logic [7:0]                       o_payload_byte,
    output logic [15:0]                      o_arg_number,
    output logic                             o_arg_end,
    output logic [23:0]                      o_header_value,
    output logic                             o_header_done,
    input  logic                             i_cfg_we,
    input  logic [mrp_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [mrp_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int ACC_W = (COUNT_BITS > LENGTH_BITS) ? COUNT_BITS : LENGTH_BITS;

    logic [15:0]            r_max_arg_count;
    logic [23:0]            r_max_arg_length;
    mrp_pkg::t_phase        r_phase,          n_phase;
    logic                   r_header_is_count, n_header_is_count;
    logic                   r_first_of_line,  n_first_of_line;
    logic [ACC_W-1:0]       r_value_acc,      n_value_acc;
    logic [COUNT_BITS-1:0]  r_args_left,      n_args_left;
    logic [COUNT_BITS-1:0]  r_arg_index,      n_arg_index;
    logic [LENGTH_BITS-1:0] r_bytes_left,     n_bytes_left;
    logic [1:0]             r_trailer_left,   n_trailer_left;
    logic                   r_out_valid;
    mrp_pkg::t_result       r_result,         n_result;
    logic                   in_accept;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;

    mrp_step #(
        .COUNT_BITS  (COUNT_BITS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_step (
        .i_data_byte       (i_data_byte),
        .i_max_arg_count   (r_max_arg_count),
        .i_max_arg_length  (r_max_arg_length),
        .i_phase           (r_phase),
        .i_header_is_count (r_header_is_count),
        .i_first_of_line   (r_first_of_line),
        .i_value_acc       (r_value_acc),
        .i_args_left       (r_args_left),
        .i_arg_index       (r_arg_index),
        .i_bytes_left      (r_bytes_left),
        .i_trailer_left    (r_trailer_left),
        .o_phase           (n_phase),
        .o_header_is_count (n_header_is_count),
        .o_first_of_line   (n_first_of_line),
        .o_value_acc       (n_value_acc),
        .o_args_left       (n_args_left),
        .o_arg_index       (n_arg_index),
        .o_bytes_left      (n_bytes_left),
        .o_trailer_left    (n_trailer_left),
        .o_result          (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_arg_count  <= 16'hFFFF;
            r_max_arg_length <= 24'hFFFFFF;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mrp_pkg::CFG_MAX_ARG_COUNT:  r_max_arg_count  <= i_cfg_data[15:0];
                mrp_pkg::CFG_MAX_ARG_LENGTH: r_max_arg_length <= i_cfg_data[23:0];
                default: r_max_arg_count <= r_max_arg_count;
            endcase
        end
    end

    // advance parse state on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase           <= mrp_pkg::PH_LINE;
            r_header_is_count <= 1'b1;
            r_first_of_line   <= 1'b1;
            r_value_acc       <= '0;
            r_args_left       <= '0;
            r_arg_index       <= '0;
            r_bytes_left      <= '0;
            r_trailer_left    <= 2'd0;
        end else if (in_accept) begin
            r_phase           <= n_phase;
            r_header_is_count <= n_header_is_count;
            r_first_of_line   <= n_first_of_line;
            r_value_acc       <= n_value_acc;
            r_args_left       <= n_args_left;
            r_arg_index       <= n_arg_index;
            r_bytes_left      <= n_bytes_left;
            r_trailer_left    <= n_trailer_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_result.kind;
    assign o_payload_byte = r_result.payload_byte;
    assign o_arg_number   = r_result.arg_number;
    assign o_arg_end      = r_result.arg_end;
    assign o_header_value = r_result.header_value;
    assign o_header_done  = r_result.header_done;

endmodule

@@ src/mrp_step.sv @@
// Per-byte next-state and result logic of the multi-bulk request parser.
module mrp_step #(
    parameter int COUNT_BITS  = 16,
    parameter int LENGTH_BITS = 24
) (
    input  logic [7:0]                  i_data_byte,
    input  logic [15:0]                 i_max_arg_count,
    input  logic [23:0]                 i_max_arg_length,
    input  mrp_pkg::t_phase             i_phase,
    input  logic                        i_header_is_count,
    input  logic                        i_first_of_line,
    input  logic [((COUNT_BITS > LENGTH_BITS) ? COUNT_BITS : LENGTH_BITS)-1:0] i_value_acc,
    input  logic [COUNT_BITS-1:0]       i_args_left,
    input  logic [COUNT_BITS-1:0]       i_arg_index,
    input  logic [LENGTH_BITS-1:0]      i_bytes_left,
    input  logic [1:0]                  i_trailer_left,
    output mrp_pkg::t_phase             o_phase,
    output logic                        o_header_is_count,
    output logic                        o_first_of_line,
    output logic [((COUNT_BITS > LENGTH_BITS) ? COUNT_BITS : LENGTH_BITS)-1:0] o_value_acc,
    output logic [COUNT_BITS-1:0]       o_args_left,
    output logic [COUNT_BITS-1:0]       o_arg_index,
    output logic [LENGTH_BITS-1:0]      o_bytes_left,
    output logic [1:0]                  o_trailer_left,
    output mrp_pkg::t_result            o_result
);

    localparam int ACC_W = (COUNT_BITS > LENGTH_BITS) ? COUNT_BITS : LENGTH_BITS;
    localparam int MUL_W = ACC_W + 4;
    localparam int CMP_W = (ACC_W > 24) ? ACC_W : 24;

    localparam logic [MUL_W-1:0] COUNT_LIM =
        {{(MUL_W-COUNT_BITS){1'b0}}, {COUNT_BITS{1'b1}}};
    localparam logic [MUL_W-1:0] LENGTH_LIM =
        {{(MUL_W-LENGTH_BITS){1'b0}}, {LENGTH_BITS{1'b1}}};

    logic             is_marker;
    logic             is_cr;
    logic             is_lf;
    logic             is_digit;
    logic [MUL_W-1:0] acc_next;
    logic [MUL_W-1:0] acc_lim;
    logic [ACC_W-1:0] acc_sat;
    logic             count_over;
    logic             length_over;
    logic             acc_zero;
    logic             err;
    logic [LENGTH_BITS-1:0] bytes_dec;
    logic [1:0]             trailer_dec;
    logic [COUNT_BITS-1:0]  args_dec;
    logic             do_restart;
    logic             do_next_line;

    assign is_marker = (i_data_byte == mrp_pkg::CH_DOLLAR) || (i_data_byte == mrp_pkg::CH_STAR);
    assign is_cr     = (i_data_byte == mrp_pkg::CH_CR);
    assign is_lf     = (i_data_byte == mrp_pkg::CH_LF);
    assign is_digit  = (i_data_byte >= mrp_pkg::CH_ZERO) && (i_data_byte <= mrp_pkg::CH_NINE);

    assign acc_next = {1'b0, i_value_acc, 3'b000} + {3'b000, i_value_acc, 1'b0}
                    + MUL_W'(i_data_byte - mrp_pkg::CH_ZERO);
    assign acc_lim  = i_header_is_count ? COUNT_LIM : LENGTH_LIM;
    assign acc_sat  = (acc_next > acc_lim) ? acc_lim[ACC_W-1:0] : acc_next[ACC_W-1:0];

    assign count_over  = CMP_W'(i_value_acc) > CMP_W'(i_max_arg_count);
    assign length_over = CMP_W'(i_value_acc) > CMP_W'(i_max_arg_length);
    assign acc_zero    = (i_value_acc == '0);

    assign bytes_dec   = i_bytes_left - LENGTH_BITS'(1);
    assign trailer_dec = i_trailer_left - 2'd1;
    assign args_dec    = i_args_left - COUNT_BITS'(1);

    always_comb begin
        err = 1'b0;
        case (i_phase)
            mrp_pkg::PH_LINE: begin
                if (i_first_of_line) begin
                    err = !(is_marker || is_cr);
                end else begin
                    err = !(is_digit || is_cr);
                end
            end
            mrp_pkg::PH_AFTER_CR: begin
                if (is_lf) begin
                    err = i_header_is_count ? count_over : length_over;
                end else begin
                    err = !is_cr;
                end
            end
            default: err = 1'b0;
        endcase
    end

    // next state
    always_comb begin
        o_phase           = i_phase;
        o_header_is_count = i_header_is_count;
        o_first_of_line   = i_first_of_line;
        o_value_acc       = i_value_acc;
        o_args_left       = i_args_left;
        o_arg_index       = i_arg_index;
        o_bytes_left      = i_bytes_left;
        o_trailer_left    = i_trailer_left;
        do_restart        = 1'b0;
        do_next_line      = 1'b0;
        case (i_phase)
            mrp_pkg::PH_LINE: begin
                if (i_first_of_line) begin
                    if (is_marker) begin
                        o_first_of_line = 1'b0;
                    end else if (is_cr) begin
                        o_first_of_line = 1'b0;
                        o_phase         = mrp_pkg::PH_AFTER_CR;
                    end
                end else if (is_digit) begin
                    o_value_acc = acc_sat;
                end else if (is_cr) begin
                    o_phase = mrp_pkg::PH_AFTER_CR;
                end
            end
            mrp_pkg::PH_AFTER_CR: begin
                if (is_lf) begin
                    if (i_header_is_count) begin
                        if (acc_zero) begin
                            do_restart = 1'b1;
                        end else begin
                            o_args_left       = i_value_acc[COUNT_BITS-1:0];
                            o_arg_index       = '0;
                            o_header_is_count = 1'b0;
                            do_next_line      = 1'b1;
                        end
                    end else begin
                        o_bytes_left = i_value_acc[LENGTH_BITS-1:0];
                        o_value_acc  = '0;
                        if (acc_zero) begin
                            o_phase        = mrp_pkg::PH_TRAILER;
                            o_trailer_left = mrp_pkg::TRAILER_BYTES;
                        end else begin
                            o_phase = mrp_pkg::PH_PAYLOAD;
                        end
                    end
                end
            end
            mrp_pkg::PH_PAYLOAD: begin
                o_bytes_left = bytes_dec;
                if (bytes_dec == '0) begin
                    o_phase        = mrp_pkg::PH_TRAILER;
                    o_trailer_left = mrp_pkg::TRAILER_BYTES;
                end
            end
            default: begin
                o_trailer_left = trailer_dec;
                if (trailer_dec == 2'd0) begin
                    o_args_left = args_dec;
                    o_arg_index = i_arg_index + COUNT_BITS'(1);
                    if (args_dec == '0) begin
                        do_restart = 1'b1;
                    end else begin
                        do_next_line = 1'b1;
                    end
                end
            end
        endcase
        if (do_next_line) begin
            o_phase         = mrp_pkg::PH_LINE;
            o_first_of_line = 1'b1;
            o_value_acc     = '0;
        end
        if (do_restart || err) begin
            o_phase           = mrp_pkg::PH_LINE;
            o_header_is_count = 1'b1;
            o_first_of_line   = 1'b1;
            o_value_acc       = '0;
            o_args_left       = '0;
            o_arg_index       = '0;
            o_bytes_left      = '0;
            o_trailer_left    = 2'd0;
        end
    end

    // result
    always_comb begin
        o_result = '{kind: mrp_pkg::KIND_FRAME, payload_byte: 8'd0, arg_number: 16'd0,
                     arg_end: 1'b0, header_value: 24'd0, header_done: 1'b0};
        case (i_phase)
            mrp_pkg::PH_AFTER_CR: begin
                if (is_lf) begin
                    o_result.header_value = 24'(i_value_acc);
                    o_result.header_done  = 1'b1;
                    if (i_header_is_count && acc_zero) begin
                        o_result.kind = mrp_pkg::KIND_DONE;
                    end
                end
            end
            mrp_pkg::PH_PAYLOAD: begin
                o_result.kind         = mrp_pkg::KIND_DATA;
                o_result.payload_byte = i_data_byte;
                o_result.arg_number   = 16'(i_arg_index);
                o_result.arg_end      = (bytes_dec == '0);
            end
            mrp_pkg::PH_TRAILER: begin
                if ((trailer_dec == 2'd0) && (args_dec == '0)) begin
                    o_result.kind = mrp_pkg::KIND_DONE;
                end
            end
            default: o_result.kind = mrp_pkg::KIND_FRAME;
        endcase
        if (err) begin
            o_result = '{kind: mrp_pkg::KIND_ERROR, payload_byte: 8'd0, arg_number: 16'd0,
                         arg_end: 1'b0, header_value: 24'd0, header_done: 1'b0};
        end
    end

endmodule

@@ test/tb_multibulk_request_parser_unit.sv @@
// Testbench for multibulk_request_parser_unit: random request streams checked beat by beat.
`timescale 1ns / 1ps

class parse_scoreboard;
    mrp_pkg::t_result pending_results[$];
    int               failures;
    logic [15:0]      lim_count;
    logic [23:0]      lim_length;
    mrp_pkg::t_phase  stage;
    bit               want_count;
    bit               at_line_start;
    logic [23:0]      number;
    logic [15:0]      args_to_go;
    logic [15:0]      arg_pos;
    logic [23:0]      payload_to_go;
    logic [1:0]       trailer_to_go;

    function new();
        failures = 0;
        lim_count = 16'hFFFF;
        lim_length = 24'hFFFFFF;
        start_over();
    endfunction

    function void start_over();
        stage = mrp_pkg::PH_LINE;
        want_count = 1'b1;
        at_line_start = 1'b1;
        number = '0;
        args_to_go = '0;
        arg_pos = '0;
        payload_to_go = '0;
        trailer_to_go = '0;
    endfunction

    function void open_line();
        stage = mrp_pkg::PH_LINE;
        at_line_start = 1'b1;
        number = '0;
    endfunction

    function void set_limit(logic [mrp_pkg::CFG_INDEX_W-1:0] idx, logic [23:0] value);
        if (idx == mrp_pkg::CFG_MAX_ARG_COUNT) lim_count = value[15:0];
        else lim_length = value;
    endfunction

    function void parse_byte(logic [7:0] c);
        mrp_pkg::t_result r;
        bit               bad;
        longint unsigned  v;
        longint unsigned  cap;
        r = '0;
        r.kind = mrp_pkg::KIND_FRAME;
        bad = 1'b0;
        case (stage)
            mrp_pkg::PH_LINE: begin
                if (at_line_start) begin
                    if (c == mrp_pkg::CH_DOLLAR || c == mrp_pkg::CH_STAR) at_line_start = 1'b0;
                    else if (c == mrp_pkg::CH_CR) begin
                        at_line_start = 1'b0;
                        stage = mrp_pkg::PH_AFTER_CR;
                    end else bad = 1'b1;
                end else if (c >= mrp_pkg::CH_ZERO && c <= mrp_pkg::CH_NINE) begin
                    cap = want_count ? 64'hFFFF : 64'hFFFFFF;
                    v = 64'(number);
                    v = v * 10 + 64'(c - mrp_pkg::CH_ZERO);
                    number = (v > cap) ? cap[23:0] : v[23:0];
                end else if (c == mrp_pkg::CH_CR) stage = mrp_pkg::PH_AFTER_CR;
                else bad = 1'b1;
            end
            mrp_pkg::PH_AFTER_CR: begin
                if (c != mrp_pkg::CH_CR) begin
                    if (c != mrp_pkg::CH_LF) bad = 1'b1;
                    else if (want_count) begin
                        if (number > 24'(lim_count)) bad = 1'b1;
                        else begin
                            r.header_value = number;
                            r.header_done = 1'b1;
                            if (number == 24'd0) begin
                                r.kind = mrp_pkg::KIND_DONE;
                                start_over();
                            end else begin
                                args_to_go = number[15:0];
                                arg_pos = '0;
                                want_count = 1'b0;
                                open_line();
                            end
                        end
                    end else if (number > lim_length) bad = 1'b1;
                    else begin
                        r.header_value = number;
                        r.header_done = 1'b1;
                        payload_to_go = number;
                        number = '0;
                        if (payload_to_go == 24'd0) begin
                            stage = mrp_pkg::PH_TRAILER;
                            trailer_to_go = mrp_pkg::TRAILER_BYTES;
                        end else stage = mrp_pkg::PH_PAYLOAD;
                    end
                end
            end
            mrp_pkg::PH_PAYLOAD: begin
                r.kind = mrp_pkg::KIND_DATA;
                r.payload_byte = c;
                r.arg_number = arg_pos;
                payload_to_go = payload_to_go - 24'd1;
                if (payload_to_go == 24'd0) begin
                    r.arg_end = 1'b1;
                    stage = mrp_pkg::PH_TRAILER;
                    trailer_to_go = mrp_pkg::TRAILER_BYTES;
                end
            end
            default: begin
                trailer_to_go = trailer_to_go - 2'd1;
                if (trailer_to_go == 2'd0) begin
                    args_to_go = args_to_go - 16'd1;
                    arg_pos = arg_pos + 16'd1;
                    if (args_to_go == 16'd0) begin
                        r.kind = mrp_pkg::KIND_DONE;
                        start_over();
                    end else open_line();
                end
            end
        endcase
        if (bad) begin
            start_over();
            r = '0;
            r.kind = mrp_pkg::KIND_ERROR;
        end
        pending_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
        if (want !== seen) begin
            $error("%s: expected %0d, actual %0d", name, want, seen);
            failures++;
        end
    endfunction

    function void check_beat(mrp_pkg::t_result seen);
        mrp_pkg::t_result want;
        if (pending_results.size() == 0) begin
            $error("result beat with no byte pending, kind %0d", seen.kind);
            failures++;
            return;
        end
        want = pending_results.pop_front();
        compare_field("kind", 32'(want.kind), 32'(seen.kind));
        compare_field("payload_byte", 32'(want.payload_byte), 32'(seen.payload_byte));
        compare_field("arg_number", 32'(want.arg_number), 32'(seen.arg_number));
        compare_field("arg_end", 32'(want.arg_end), 32'(seen.arg_end));
        compare_field("header_value", 32'(want.header_value), 32'(seen.header_value));
        compare_field("header_done", 32'(want.header_done), 32'(seen.header_done));
    endfunction
endclass

module tb_multibulk_request_parser_unit;

    localparam logic [7:0] CH_JUNK = 8'h78;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_in_valid = 1'b0;
    logic                            o_in_stall;
    logic [7:0]                      i_data_byte = 8'h00;
    logic                            o_out_valid;
    logic                            i_out_stall = 1'b0;
    logic [1:0]                      o_kind;
    logic [7:0]                      o_payload_byte;
    logic [15:0]                     o_arg_number;
    logic                            o_arg_end;
    logic [23:0]                     o_header_value;
    logic                            o_header_done;
    logic                            i_cfg_we = 1'b0;
    logic [mrp_pkg::CFG_INDEX_W-1:0] i_cfg_index = mrp_pkg::CFG_MAX_ARG_COUNT;
    logic [mrp_pkg::CFG_DATA_W-1:0]  i_cfg_data = '0;

    parse_scoreboard sb;
    int bytes_sent = 0;
    int in_gap_max = 14;
    int out_gap_max = 14;
    int hold_cycles = 0;
    int req_pos = 0;
    int corrupt_pos = -1;

    multibulk_request_parser_unit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_kind         (o_kind),
        .o_payload_byte (o_payload_byte),
        .o_arg_number   (o_arg_number),
        .o_arg_end      (o_arg_end),
        .o_header_value (o_header_value),
        .o_header_done  (o_header_done),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = $urandom_range(0, in_gap_max);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        sb.parse_byte(b);
        bytes_sent++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending_results.size() != 0);
    endtask

    task automatic write_limits(input logic [15:0] count_lim, input logic [23:0] length_lim);
        i_cfg_we <= 1'b1;
        i_cfg_index <= mrp_pkg::CFG_MAX_ARG_COUNT;
        i_cfg_data <= {8'h00, count_lim};
        @(posedge i_clk);
        sb.set_limit(mrp_pkg::CFG_MAX_ARG_COUNT, {8'h00, count_lim});
        i_cfg_index <= mrp_pkg::CFG_MAX_ARG_LENGTH;
        i_cfg_data <= length_lim;
        @(posedge i_clk);
        sb.set_limit(mrp_pkg::CFG_MAX_ARG_LENGTH, length_lim);
        i_cfg_we <= 1'b0;
    endtask

    // keep stray digits from building a long header
    function automatic logic [7:0] steer(input logic [7:0] b);
        if (b >= mrp_pkg::CH_ZERO && b <= mrp_pkg::CH_NINE && sb.stage == mrp_pkg::PH_LINE
                && !sb.at_line_start && sb.number >= 24'd10)
            return mrp_pkg::CH_CR;
        return b;
    endfunction

    task automatic put(input logic [7:0] b);
        if (req_pos == corrupt_pos) b = steer(8'($urandom_range(0, 255)));
        else if (corrupt_pos >= 0 && req_pos > corrupt_pos) b = steer(b);
        req_pos++;
        send_byte(b);
    endtask

    function automatic logic [7:0] pick_marker(input bit for_count);
        bit proper;
        proper = $urandom_range(0, 6) != 0;
        return (for_count == proper) ? mrp_pkg::CH_STAR : mrp_pkg::CH_DOLLAR;
    endfunction

    task automatic send_line(input logic [7:0] marker, input longint unsigned value,
                             input bit bare);
        logic [7:0]      digs [20];
        longint unsigned v;
        logic [7:0]      d;
        int              nd;
        int              k;
        if (bare) put(mrp_pkg::CH_CR);
        else begin
            put(marker);
            v = value;
            nd = 0;
            do begin
                d = 8'(v % 10);
                digs[nd] = mrp_pkg::CH_ZERO + d;
                nd++;
                v = v / 10;
            end while (v != 0);
            if ($urandom_range(0, 5) == 0) put(mrp_pkg::CH_ZERO);
            for (k = nd - 1; k >= 0; k--) put(digs[k]);
            put(mrp_pkg::CH_CR);
        end
        if ($urandom_range(0, 5) == 0) put(mrp_pkg::CH_CR);
        put(mrp_pkg::CH_LF);
    endtask

    task automatic send_arg(output bit ok);
        longint unsigned len;
        longint unsigned eff;
        int              sel;
        sel = $urandom_range(0, 19);
        if (sel == 0 && sb.lim_length != 24'hFFFFFF) len = 64'(sb.lim_length) + 64'd1;
        else if (sel == 1 && sb.lim_length != 24'hFFFFFF) len = 64'd987654321098;
        else if (sel == 2) len = 64'($urandom_range(9, 40));
        else len = 64'($urandom_range(0, 8));
        eff = (len > 64'hFFFFFF) ? 64'hFFFFFF : len;
        send_line(pick_marker(1'b0), len, len == 0 && $urandom_range(0, 2) == 0);
        ok = eff <= 64'(sb.lim_length);
        if (ok) begin
            repeat (eff) put(8'($urandom_range(0, 255)));
            put(8'($urandom_range(0, 255)));
            put(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic send_request(input bit broken);
        longint unsigned cnt;
        longint unsigned eff;
        logic [7:0]      b;
        int              sel;
        int              n;
        int              k;
        bit              ok;
        while (!(sb.stage == mrp_pkg::PH_LINE && sb.want_count && sb.at_line_start)) begin
            if (sb.stage == mrp_pkg::PH_PAYLOAD || sb.stage == mrp_pkg::PH_TRAILER)
                b = 8'($urandom_range(0, 255));
            else b = CH_JUNK;
            send_byte(b);
        end
        req_pos = 0;
        corrupt_pos = broken ? int'($urandom_range(0, 15)) : -1;
        sel = $urandom_range(0, 19);
        if (sel == 0) cnt = 0;
        else if (sel == 1) cnt = 64'(sb.lim_count) + 64'd1;
        else if (sel == 2) cnt = 64'd123456789012;
        else if (sel == 3) cnt = 64'($urandom_range(5, 65535));
        else cnt = 64'($urandom_range(1, 4));
        eff = (cnt > 64'hFFFF) ? 64'hFFFF : cnt;
        send_line(pick_marker(1'b1), cnt, cnt == 0 && $urandom_range(0, 1) == 0);
        if (eff != 0 && eff <= 64'(sb.lim_count)) begin
            n = (eff > 4) ? 1 : int'(eff);
            ok = 1'b1;
            for (k = 0; k < n && ok; k++) send_arg(ok);
            if (ok && n < eff) put(CH_JUNK);
        end
        corrupt_pos = -1;
    endtask

    task automatic send_noise();
        logic [7:0] b;
        int         n;
        int         k;
        n = $urandom_range(1, 4);
        for (k = 0; k < n; k++) begin
            case ($urandom_range(0, 3))
                0: b = 8'($urandom_range(0, 255));
                1: b = mrp_pkg::CH_ZERO + 8'($urandom_range(0, 9));
                2: b = $urandom_range(0, 1) ? mrp_pkg::CH_CR : mrp_pkg::CH_LF;
                default: b = $urandom_range(0, 1) ? mrp_pkg::CH_DOLLAR : mrp_pkg::CH_STAR;
            endcase
            send_byte(steer(b));
        end
    endtask

    initial begin : result_sink
        mrp_pkg::t_result got;
        int               gap;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_cycles != 0) begin
                gap = hold_cycles;
                hold_cycles = 0;
            end else gap = $urandom_range(0, out_gap_max);
            if (gap != 0) begin
                i_out_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            got = mrp_pkg::t_result'({o_kind, o_payload_byte, o_arg_number, o_arg_end,
                                      o_header_value, o_header_done});
            sb.check_beat(got);
        end
    end

    initial begin : stimulus
        logic [8*26-1:0] opening;
        int              ph;
        int              k;
        int              target;
        int              pick;
        sb = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        opening = {mrp_pkg::CH_LF, mrp_pkg::CH_CR, mrp_pkg::CH_LF, mrp_pkg::CH_STAR,
                   mrp_pkg::CH_STAR, mrp_pkg::CH_STAR, "1", mrp_pkg::CH_CR, "5",
                   mrp_pkg::CH_STAR, "2", mrp_pkg::CH_CR, mrp_pkg::CH_CR, mrp_pkg::CH_LF,
                   mrp_pkg::CH_DOLLAR, mrp_pkg::CH_CR, mrp_pkg::CH_LF, 8'h00, 8'hFF,
                   mrp_pkg::CH_DOLLAR, "1", mrp_pkg::CH_CR, mrp_pkg::CH_LF, 8'hFF, 8'h00,
                   mrp_pkg::CH_LF};
        for (k = 25; k >= 0; k--) send_byte(opening[k*8 +: 8]);
        drain();

        for (ph = 0; ph < 7; ph++) begin
            in_gap_max = (ph == 1 || ph == 2) ? 0 : 14;
            out_gap_max = (ph == 1 || ph == 3) ? 0 : 14;
            case (ph)
                1: write_limits(16'd0, 24'd0);
                2: write_limits(16'd3, 24'd5);
                3: write_limits(16'hFFFF, 24'hFFFFFF);
                4: write_limits(16'($urandom_range(1, 6)), 24'($urandom_range(0, 8)));
                5: write_limits(16'($urandom_range(0, 65535)),
                                24'($urandom_range(0, 24'hFFFFFE)));
                6: write_limits(16'd1, 24'd0);
                default: ;
            endcase
            if (ph == 2) hold_cycles = 90;
            target = bytes_sent + 160;
            while (bytes_sent < target) begin
                pick = $urandom_range(0, 9);
                if (pick < 7) send_request(1'b0);
                else if (pick < 9) send_request(1'b1);
                else send_noise();
            end
            drain();
        end

        repeat (4) @(posedge i_clk);
        if (sb.failures == 0 && sb.pending_results.size() == 0)
            $display("PASS multibulk_request_parser_unit");
        else
            $display("FAIL multibulk_request_parser_unit");
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("FAIL multibulk_request_parser_unit");
        $finish;
    end

endmodule
